### hw/rtl/x86ag_pkg.sv
// package for the x86 modrm address generator: codes, sizes and the
// decode result bundle. no dependencies
`timescale 1ns / 1ps

package x86ag_pkg;

   localparam int NUM_REGS = 8;
   localparam int REG_AW   = 3;
   localparam int DATA_W   = 32;
   localparam int CODE_W   = 48;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_DECODE = 2'd2;

   // access sizes
   localparam logic [1:0] SZ_BYTE  = 2'd0;
   localparam logic [1:0] SZ_WORD  = 2'd1;
   localparam logic [1:0] SZ_DWORD = 2'd2;
   localparam logic [1:0] SZ_NONE  = 2'd3;

   // segment codes
   localparam logic [2:0] SEG_ES = 3'd0;
   localparam logic [2:0] SEG_CS = 3'd1;
   localparam logic [2:0] SEG_SS = 3'd2;
   localparam logic [2:0] SEG_DS = 3'd3;
   localparam logic [2:0] SEG_FS = 3'd4;
   localparam logic [2:0] SEG_GS = 3'd5;

   // segment override prefix bytes
   localparam logic [7:0] PFX_ES = 8'h26;
   localparam logic [7:0] PFX_CS = 8'h2e;
   localparam logic [7:0] PFX_SS = 8'h36;
   localparam logic [7:0] PFX_DS = 8'h3e;
   localparam logic [7:0] PFX_FS = 8'h64;
   localparam logic [7:0] PFX_GS = 8'h65;

   // register numbers used by the addressing forms
   localparam logic [REG_AW-1:0] REG_SP = 3'd4;
   localparam logic [REG_AW-1:0] REG_BX = 3'd3;
   localparam logic [REG_AW-1:0] REG_BP = 3'd5;
   localparam logic [REG_AW-1:0] REG_SI = 3'd6;
   localparam logic [REG_AW-1:0] REG_DI = 3'd7;

   // modrm field values with special meaning
   localparam logic [1:0] MOD_NODISP = 2'd0;
   localparam logic [1:0] MOD_DISP8  = 2'd1;
   localparam logic [1:0] MOD_DISPW  = 2'd2;
   localparam logic [1:0] MOD_REG    = 2'd3;
   localparam logic [2:0] RM_SIB     = 3'd4;
   localparam logic [2:0] RM_DISP32  = 3'd5;
   localparam logic [2:0] RM_DISP16  = 3'd6;

   // 16-bit rm addressing forms
   localparam logic [2:0] RM16_BX_SI = 3'd0;
   localparam logic [2:0] RM16_BX_DI = 3'd1;
   localparam logic [2:0] RM16_BP_SI = 3'd2;
   localparam logic [2:0] RM16_BP_DI = 3'd3;
   localparam logic [2:0] RM16_SI    = 3'd4;
   localparam logic [2:0] RM16_DI    = 3'd5;
   localparam logic [2:0] RM16_BP    = 3'd6;
   localparam logic [2:0] RM16_BX    = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] address;
      logic [2:0]        segment;
      logic [2:0]        bytes_used;
      logic [1:0]        mod_field;
      logic [2:0]        reg_field;
      logic [2:0]        rm_field;
      logic              register_operand;
      logic              has_sib;
      logic              has_displacement;
   } ea_result_type;

endpackage

### hw/rtl/x86ag_ram.sv
// generic synchronous ram: one write port, two read ports, registered reads
// no dependencies
`timescale 1ns / 1ps

module x86ag_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### hw/rtl/x86ag_ea.sv
// modrm/sib decode and effective address arithmetic on fetched register values
// depends on x86ag_pkg
`timescale 1ns / 1ps

module x86ag_ea (
   input  logic [x86ag_pkg::CODE_W-1:0] code,
   input  logic                         addr32,
   input  logic [7:0]                   segment_prefix,
   input  logic [x86ag_pkg::DATA_W-1:0] base_data,
   input  logic [x86ag_pkg::DATA_W-1:0] index_data,
   output x86ag_pkg::ea_result_type     result
);

   logic [1:0]  mod_f;
   logic [2:0]  reg_f;
   logic [2:0]  rm_f;
   logic [1:0]  scale;
   logic [2:0]  sib_index;
   logic [2:0]  sib_base;
   logic        sib;
   logic        stack;
   logic        no_base;
   logic [2:0]  disp_len;
   logic [31:0] disp_win;
   logic [31:0] disp;
   logic [31:0] base_term;
   logic [31:0] index_term;
   logic [31:0] ea32;
   logic [15:0] ea16;
   logic [15:0] term_a16;
   logic [15:0] term_b16;
   logic [2:0]  pfx_seg;
   logic        pfx_hit;

   assign mod_f     = code[7:6];
   assign reg_f     = code[5:3];
   assign rm_f      = code[2:0];
   assign scale     = code[15:14];
   assign sib_index = code[13:11];
   assign sib_base  = code[10:8];

   always_comb begin
      sib      = 1'b0;
      stack    = 1'b0;
      no_base  = 1'b0;
      disp_len = 3'd0;
      if (!addr32) begin
         if (mod_f == x86ag_pkg::MOD_DISP8) begin
            disp_len = 3'd1;
         end else if (mod_f == x86ag_pkg::MOD_DISPW || rm_f == x86ag_pkg::RM_DISP16) begin
            disp_len = 3'd2;
         end
         stack = (rm_f == x86ag_pkg::RM16_BP_SI) || (rm_f == x86ag_pkg::RM16_BP_DI) ||
                 (rm_f == x86ag_pkg::RM_DISP16 && mod_f != x86ag_pkg::MOD_NODISP);
      end else begin
         if (mod_f == x86ag_pkg::MOD_DISP8) begin
            disp_len = 3'd1;
         end else if (mod_f == x86ag_pkg::MOD_DISPW || rm_f == x86ag_pkg::RM_DISP32) begin
            disp_len = 3'd4;
         end
         if (rm_f == x86ag_pkg::RM_SIB) begin
            sib = 1'b1;
            // sib base of ebp with no displacement mode means disp32, no base
            if (sib_base == x86ag_pkg::REG_BP && mod_f == x86ag_pkg::MOD_NODISP) begin
               disp_len = 3'd4;
               no_base  = 1'b1;
            end else if (sib_base == x86ag_pkg::REG_SP || sib_base == x86ag_pkg::REG_BP) begin
               stack = 1'b1;
            end
         end else if (rm_f == x86ag_pkg::RM_DISP32) begin
            if (mod_f != x86ag_pkg::MOD_NODISP) begin
               stack = 1'b1;
            end else begin
               no_base = 1'b1;
            end
         end
      end
   end

   // displacement starts right after modrm, or after the sib byte
   assign disp_win = sib ? code[47:16] : code[39:8];

   always_comb begin
      case (disp_len)
         3'd1:    disp = {{24{disp_win[7]}}, disp_win[7:0]};
         3'd2:    disp = {16'h0000, disp_win[15:0]};
         3'd4:    disp = disp_win;
         default: disp = 32'h0000_0000;
      endcase
   end

   assign base_term  = no_base ? 32'h0000_0000 : base_data;
   assign index_term = (sib && sib_index != x86ag_pkg::REG_SP) ? (index_data << scale)
                                                               : 32'h0000_0000;
   assign ea32 = index_term + base_term + disp;

   // 16-bit forms: port a carries bx or bp, port b carries si or di
   always_comb begin
      term_a16 = 16'h0000;
      term_b16 = 16'h0000;
      if (!(mod_f == x86ag_pkg::MOD_NODISP && rm_f == x86ag_pkg::RM_DISP16)) begin
         if (rm_f != x86ag_pkg::RM16_SI && rm_f != x86ag_pkg::RM16_DI) begin
            term_a16 = base_data[15:0];
         end
         if (rm_f != x86ag_pkg::RM16_BP && rm_f != x86ag_pkg::RM16_BX) begin
            term_b16 = index_data[15:0];
         end
      end
   end

   assign ea16 = disp[15:0] + term_a16 + term_b16;

   always_comb begin
      pfx_hit = 1'b1;
      case (segment_prefix)
         x86ag_pkg::PFX_ES: pfx_seg = x86ag_pkg::SEG_ES;
         x86ag_pkg::PFX_CS: pfx_seg = x86ag_pkg::SEG_CS;
         x86ag_pkg::PFX_SS: pfx_seg = x86ag_pkg::SEG_SS;
         x86ag_pkg::PFX_DS: pfx_seg = x86ag_pkg::SEG_DS;
         x86ag_pkg::PFX_FS: pfx_seg = x86ag_pkg::SEG_FS;
         x86ag_pkg::PFX_GS: pfx_seg = x86ag_pkg::SEG_GS;
         default: begin
            pfx_seg = x86ag_pkg::SEG_DS;
            pfx_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.mod_field        = mod_f;
      result.reg_field        = reg_f;
      result.rm_field         = rm_f;
      result.register_operand = (mod_f == x86ag_pkg::MOD_REG);
      if (mod_f == x86ag_pkg::MOD_REG) begin
         result.address          = 32'h0000_0000;
         result.segment          = x86ag_pkg::SEG_DS;
         result.bytes_used       = 3'd1;
         result.has_sib          = 1'b0;
         result.has_displacement = 1'b0;
      end else begin
         result.address          = addr32 ? ea32 : {16'h0000, ea16};
         result.segment          = pfx_hit ? pfx_seg
                                 : (stack ? x86ag_pkg::SEG_SS : x86ag_pkg::SEG_DS);
         result.bytes_used       = 3'd1 + {2'b00, sib} + disp_len;
         result.has_sib          = sib;
         result.has_displacement = (disp_len != 3'd0);
      end
   end

endmodule

### hw/rtl/x86_modrm_address_generation.sv
// top level: x86 general-register file in a synchronous ram plus modrm address generator
// depends on x86ag_pkg, x86ag_ram, x86ag_ea
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  operation, reg_index, access_size, write_value,
//                                            code_bytes, address_size_override, segment_prefix
//   rsp_     out        rsp_valid/rsp_ready  read_data, effective_address, segment_select,
//                                            bytes_used, mod/reg/rm fields, flags
//   csr_     in         csr_write_enable     protected_mode
//
// every item goes through the ram read of up to two registers issued at accept,
// then the compute/write-back cycle that loads the output register.
// the output register lets the next item be accepted while a beat waits on rsp_ready;
// a finished item holds in the compute cycle only while the output register is full.
// after reset all registers read as zero through per-entry valid bits, no clearing pass.
`timescale 1ns / 1ps

module x86_modrm_address_generation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_reg_index,
   input  logic [1:0]  req_access_size,
   input  logic [31:0] req_write_value,
   input  logic [47:0] req_code_bytes,
   input  logic        req_address_size_override,
   input  logic [7:0]  req_segment_prefix,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [31:0] rsp_effective_address,
   output logic [2:0]  rsp_segment_select,
   output logic [2:0]  rsp_bytes_used,
   output logic [1:0]  rsp_mod_field,
   output logic [2:0]  rsp_reg_field,
   output logic [2:0]  rsp_rm_field,
   output logic        rsp_register_operand,
   output logic        rsp_has_sib,
   output logic        rsp_has_displacement,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic protected_mode_ff;
   logic [x86ag_pkg::NUM_REGS-1:0] valid_ff;
   logic [x86ag_pkg::NUM_REGS-1:0] valid_in;

   logic [1:0]                   op_ff;
   logic [2:0]                   idx_ff;
   logic [1:0]                   size_ff;
   logic [31:0]                  wdata_ff;
   logic [47:0]                  code_ff;
   logic                         addr32_ff;
   logic [7:0]                   segpfx_ff;
   logic [x86ag_pkg::REG_AW-1:0] ra_ff;
   logic [x86ag_pkg::REG_AW-1:0] rb_ff;

   logic                         accept;
   logic                         exec_go;
   logic                         addr32_req;
   logic [x86ag_pkg::REG_AW-1:0] ra_req;
   logic [x86ag_pkg::REG_AW-1:0] rb_req;
   logic [2:0]                   rm_req;
   logic [31:0]                  ram_a;
   logic [31:0]                  ram_b;
   logic [31:0]                  reg_a;
   logic [31:0]                  reg_b;
   logic                         wr_en;
   logic [31:0]                  wr_data;
   logic [31:0]                  rd_value;
   x86ag_pkg::ea_result_type     ea_res;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_read_data_ff;
   logic [31:0] rsp_read_data_in;
   x86ag_pkg::ea_result_type rsp_ea_ff;
   x86ag_pkg::ea_result_type rsp_ea_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign addr32_req = protected_mode_ff ^ req_address_size_override;
   assign rm_req     = req_code_bytes[2:0];

   // register addresses for the read issued at accept
   always_comb begin
      ra_req = x86ag_pkg::REG_BX;
      rb_req = x86ag_pkg::REG_SI;
      case (req_operation)
         x86ag_pkg::OP_READ, x86ag_pkg::OP_WRITE: begin
            ra_req = (req_access_size == x86ag_pkg::SZ_BYTE) ? {1'b0, req_reg_index[1:0]}
                                                             : req_reg_index;
         end
         x86ag_pkg::OP_DECODE: begin
            if (addr32_req) begin
               ra_req = (rm_req == x86ag_pkg::RM_SIB) ? req_code_bytes[10:8] : rm_req;
               rb_req = req_code_bytes[13:11];
            end else begin
               ra_req = (rm_req == x86ag_pkg::RM16_BP_SI || rm_req == x86ag_pkg::RM16_BP_DI ||
                         rm_req == x86ag_pkg::RM16_BP) ? x86ag_pkg::REG_BP
                                                       : x86ag_pkg::REG_BX;
               rb_req = rm_req[0] ? x86ag_pkg::REG_DI : x86ag_pkg::REG_SI;
            end
         end
         default: begin
            ra_req = x86ag_pkg::REG_BX;
         end
      endcase
   end

   x86ag_ram #(
      .WIDTH(x86ag_pkg::DATA_W),
      .DEPTH(x86ag_pkg::NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ra_ff),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (ra_req),
      .rd_addr_b (rb_req),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // never-written entries read as zero
   assign reg_a = valid_ff[ra_ff] ? ram_a : 32'h0000_0000;
   assign reg_b = valid_ff[rb_ff] ? ram_b : 32'h0000_0000;

   x86ag_ea u_ea (
      .code           (code_ff),
      .addr32         (addr32_ff),
      .segment_prefix (segpfx_ff),
      .base_data      (reg_a),
      .index_data     (reg_b),
      .result         (ea_res)
   );

   // read value and read-modify-write merge
   always_comb begin
      rd_value = 32'h0000_0000;
      wr_data  = reg_a;
      case (size_ff)
         x86ag_pkg::SZ_BYTE: begin
            rd_value = idx_ff[2] ? {24'h000000, reg_a[15:8]} : {24'h000000, reg_a[7:0]};
            wr_data  = idx_ff[2] ? {reg_a[31:16], wdata_ff[7:0], reg_a[7:0]}
                                 : {reg_a[31:8], wdata_ff[7:0]};
         end
         x86ag_pkg::SZ_WORD: begin
            rd_value = {16'h0000, reg_a[15:0]};
            wr_data  = {reg_a[31:16], wdata_ff[15:0]};
         end
         x86ag_pkg::SZ_DWORD: begin
            rd_value = reg_a;
            wr_data  = wdata_ff;
         end
         default: begin
            rd_value = 32'h0000_0000;
            wr_data  = reg_a;
         end
      endcase
   end

   assign wr_en = exec_go && (op_ff == x86ag_pkg::OP_WRITE) && (size_ff != x86ag_pkg::SZ_NONE);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[ra_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_read_data_in = (op_ff == x86ag_pkg::OP_READ) ? rd_value : 32'h0000_0000;
      rsp_ea_in        = (op_ff == x86ag_pkg::OP_DECODE) ? ea_res : '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         protected_mode_ff <= 1'b0;
         valid_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            protected_mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         idx_ff    <= req_reg_index;
         size_ff   <= req_access_size;
         wdata_ff  <= req_write_value;
         code_ff   <= req_code_bytes;
         addr32_ff <= addr32_req;
         segpfx_ff <= req_segment_prefix;
         ra_ff     <= ra_req;
         rb_ff     <= rb_req;
      end
      if (exec_go) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_ea_ff        <= rsp_ea_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_read_data_ff;
   assign rsp_effective_address = rsp_ea_ff.address;
   assign rsp_segment_select    = rsp_ea_ff.segment;
   assign rsp_bytes_used        = rsp_ea_ff.bytes_used;
   assign rsp_mod_field         = rsp_ea_ff.mod_field;
   assign rsp_reg_field         = rsp_ea_ff.reg_field;
   assign rsp_rm_field          = rsp_ea_ff.rm_field;
   assign rsp_register_operand  = rsp_ea_ff.register_operand;
   assign rsp_has_sib           = rsp_ea_ff.has_sib;
   assign rsp_has_displacement  = rsp_ea_ff.has_displacement;

   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted beat did not enter compute cycle");

   a_write_sets_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(ra_ff)])
      else $error("register write did not mark entry valid");

   a_rsp_from_exec : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result beat appeared without a compute cycle");

   a_exec_holds : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && rsp_valid_ff && !rsp_ready |=> state_ff == ST_EXEC)
      else $error("compute cycle left while output register full");

endmodule
